// ===== rtl/core/tqle_pkg.sv =====
package tqle_pkg;

    typedef enum logic [1:0] {
        CMD_MAP_WRITE = 2'd0,
        CMD_LEARN     = 2'd1,
        CMD_GREEDY    = 2'd2,
        CMD_CLEAR     = 2'd3
    } cmd_t;

    localparam logic [1:0] CFG_DISCOUNT = 2'd0;
    localparam logic [1:0] CFG_EXPLORE  = 2'd1;
    localparam logic [1:0] CFG_BLOCKED  = 2'd2;
    localparam logic [1:0] CFG_TURN     = 2'd3;

    localparam logic [1:0] ACT_LEFT     = 2'd0;
    localparam logic [1:0] ACT_STRAIGHT = 2'd1;
    localparam logic [1:0] ACT_RIGHT    = 2'd2;

    localparam int Q_W = 24;
    localparam logic signed [23:0] Q_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] Q_MIN = -24'sh800000;

    // Input tdata: command, time_step, lane, map_value, explore_draw,
    // random_action, tie_draw (44 bits) padded to 48.
    localparam int S_TDATA_W = 48;
    // Output tdata: action, next_lane, step_reward, q_value, total_reward,
    // error (80 bits).
    localparam int M_TDATA_W = 80;

    // Listed from the top bit down, so command lands in the lowest bits.
    typedef struct packed {
        logic [7:0]         tie_draw;
        logic [1:0]         random_action;
        logic [6:0]         explore_draw;
        logic signed [15:0] map_value;
        logic [3:0]         lane;
        logic [4:0]         time_step;
        logic [1:0]         command;
    } req_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         next_lane;
        logic signed [16:0] step_reward;
        logic signed [23:0] q_value;
        logic signed [31:0] total_reward;
        logic               error;
    } rsp_t;

    typedef struct packed {
        logic [15:0]        discount_gain;
        logic [6:0]         explore_percent;
        logic signed [15:0] blocked_reward;
        logic signed [15:0] turn_penalty;
    } cfg_t;

    // Index of the chosen entry among up to three tied best actions.
    function automatic logic [1:0] tie_pick(input logic [7:0] draw, input logic [1:0] n);
        logic [3:0] s4;
        logic [2:0] s2;
        logic [1:0] r;
        begin
            // Four is one modulo three, so the sum of base-4 digits keeps the remainder.
            s4 = 4'(draw[1:0]) + 4'(draw[3:2]) + 4'(draw[5:4]) + 4'(draw[7:6]);
            s2 = 3'(s4[3:2]) + 3'(s4[1:0]);
            if (s2 >= 3'd3) s2 = s2 - 3'd3;
            if (s2 >= 3'd3) s2 = s2 - 3'd3;
            case (n)
                2'd2:    r = {1'b0, draw[0]};
                2'd3:    r = s2[1:0];
                default: r = 2'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/core/tqle_mac.sv =====
module tqle_mac (
    input  logic               aclk,
    input  logic               start,
    input  logic signed [23:0] max_q,
    input  logic [15:0]        gain,
    input  logic signed [16:0] reward,
    output logic signed [23:0] q_out
);
    import tqle_pkg::*;

    logic signed [40:0] prod_reg;
    logic signed [25:0] sum;
    logic signed [40:0] rnd;

    // Stage one: the product; stage two: rounding, add and clamp.
    always_ff @(posedge aclk) begin
        if (start) begin
            prod_reg <= 41'(max_q * $signed({1'b0, gain}));
        end
    end

    always_comb begin
        rnd = prod_reg + 41'sd32768;
        sum = 26'(rnd >>> 16) + 26'(reward);
        if (sum > 26'(Q_MAX)) begin
            q_out = Q_MAX;
        end else if (sum < 26'(Q_MIN)) begin
            q_out = Q_MIN;
        end else begin
            q_out = sum[23:0];
        end
    end
endmodule

// ===== rtl/core/tabular_q_learning_lane_engine.sv =====
// Channel  | Handshake        | Payload
// s_axis   | tvalid/tready    | tdata: command request fields
// m_axis   | tvalid/tready    | tdata: result fields
// cfg      | cfg_we           | cfg_index, cfg_data
// A learn step holds the block from acceptance to the next ready through capture,
// the index check, the current-row reads, the pick, the next-row reads, the multiply,
// the write back and the result. A greedy step skips the multiply. A map write or a
// bad index goes from the check straight to the result; a clear sweeps the Q memory
// one entry a cycle across all TIME_STEPS*LANES*ACTIONS entries before its result.
// After reset the Q memory is swept once the same way before any request is accepted.
// A result waits in an output register; a stall holds it and keeps s_tready low.
module tabular_q_learning_lane_engine #(
    parameter int TIME_STEPS = 32,
    parameter int LANES      = 3,
    parameter int ACTIONS    = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command, time_step, lane, map_value, explore_draw, random_action, tie_draw
    input  logic [tqle_pkg::S_TDATA_W-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // action, next_lane, step_reward, q_value, total_reward, error
    output logic [tqle_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import tqle_pkg::*;

    localparam int QD  = TIME_STEPS * LANES * ACTIONS;
    localparam int MD  = TIME_STEPS * LANES;
    localparam int QAW = $clog2(QD);
    localparam int MAW = $clog2(MD);
    localparam int TW  = $clog2(TIME_STEPS);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_RDCUR = 9'b000000100,
        S_PICK  = 9'b000001000,
        S_RDNXT = 9'b000010000,
        S_MUL   = 9'b000100000,
        S_WRITE = 9'b001000000,
        S_CLEAR = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    cfg_t   cfg_reg;
    req_t   req_reg;
    rsp_t   rsp_reg;

    logic [23:0] q_mem [QD];
    logic [15:0] m_mem [MD];
    logic [QAW-1:0] q_raddr, q_waddr;
    logic           q_we;
    logic [23:0]    q_wdata, q_rdata_reg;
    logic [15:0]    m_rdata_reg;

    logic [QAW:0]   clr_reg;
    logic [2:0]     cnt_reg;
    logic signed [23:0] cq_reg [3];
    logic signed [23:0] nmax_reg;
    logic [1:0]     act_reg;
    logic [3:0]     nl_reg;
    logic           blk_reg;
    logic signed [16:0] rew_reg;
    logic signed [31:0] total_reg;
    logic           mac_start;
    logic signed [23:0] mac_q;

    req_t s_req;
    assign s_req = req_t'(s_tdata[43:0]);

    logic [QAW-1:0] row_base_cur, row_base_nxt;
    logic [TW:0]    t_ext;
    assign t_ext = (TW+1)'(req_reg.time_step);
    assign row_base_cur = QAW'((32'(t_ext) * LANES + 32'(req_reg.lane)) * ACTIONS);
    assign row_base_nxt = QAW'(((32'(t_ext) + 32'd1) * LANES + 32'(nl_reg)) * ACTIONS);

    always_ff @(posedge aclk) begin
        if (q_we) begin
            q_mem[q_waddr] <= q_wdata;
        end
        q_rdata_reg <= q_mem[q_raddr];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_CHECK && req_reg.command == CMD_MAP_WRITE
            && 32'(req_reg.time_step) < TIME_STEPS && 32'(req_reg.lane) < LANES) begin
            m_mem[MAW'(32'(req_reg.time_step) * LANES + 32'(req_reg.lane))] <= req_reg.map_value;
        end
        m_rdata_reg <= m_mem[MAW'((32'(t_ext) + 32'd1) * LANES + 32'(nl_reg))];
    end

    tqle_mac u_mac (
        .aclk   (aclk),
        .start  (mac_start),
        .max_q  (nmax_reg),
        .gain   (cfg_reg.discount_gain),
        .reward (rew_reg),
        .q_out  (mac_q)
    );

    // Best action choice over the three current Q values.
    logic signed [23:0] bm;
    logic [1:0] ntie, tsel, best;
    logic [2:0] tmask;
    always_comb begin
        bm = cq_reg[0];
        if (cq_reg[1] > bm) bm = cq_reg[1];
        if (cq_reg[2] > bm) bm = cq_reg[2];
        tmask = {cq_reg[2] == bm, cq_reg[1] == bm, cq_reg[0] == bm};
        ntie = 2'(tmask[0]) + 2'(tmask[1]) + 2'(tmask[2]);
        tsel = tie_pick(req_reg.tie_draw, ntie);
        best = ACT_LEFT;
        if (tsel == 2'd0) begin
            best = tmask[0] ? ACT_LEFT : (tmask[1] ? ACT_STRAIGHT : ACT_RIGHT);
        end else if (tsel == 2'd1) begin
            best = tmask[0] ? (tmask[1] ? ACT_STRAIGHT : ACT_RIGHT) : ACT_RIGHT;
        end else begin
            best = ACT_RIGHT;
        end
    end

    logic [1:0] pick;
    logic       pblk;
    logic [3:0] pnl;
    always_comb begin
        if (req_reg.command == CMD_LEARN && req_reg.explore_draw < cfg_reg.explore_percent)
            pick = (req_reg.random_action == 2'd3) ? ACT_LEFT : req_reg.random_action;
        else
            pick = best;
        pblk = (pick == ACT_LEFT && req_reg.lane == 4'd0)
            || (pick == ACT_RIGHT && 32'(req_reg.lane) == LANES - 1);
        pnl = req_reg.lane;
        if (!pblk && pick == ACT_LEFT)  pnl = req_reg.lane - 4'd1;
        if (!pblk && pick == ACT_RIGHT) pnl = req_reg.lane + 4'd1;
    end

    logic bad_idx;
    always_comb begin
        if (req_reg.command == CMD_MAP_WRITE)
            bad_idx = 32'(req_reg.time_step) >= TIME_STEPS || 32'(req_reg.lane) >= LANES;
        else
            bad_idx = 32'(req_reg.time_step) + 1 >= TIME_STEPS || 32'(req_reg.lane) >= LANES;
    end

    logic signed [16:0] rew_c;
    logic signed [32:0] tot_sum;
    always_comb begin
        rew_c = blk_reg ? 17'(cfg_reg.blocked_reward) : 17'($signed(m_rdata_reg));
        if (act_reg != ACT_STRAIGHT) rew_c = rew_c + 17'(cfg_reg.turn_penalty);
        tot_sum = (req_reg.time_step == 5'd0 ? 33'sd0 : 33'(total_reg)) + 33'(rew_reg);
    end

    always_comb begin
        state_next = state_reg;
        q_raddr = row_base_cur + QAW'(cnt_reg[1:0]);
        q_we = 1'b0;
        q_waddr = QAW'(clr_reg);
        q_wdata = '0;
        mac_start = 1'b0;
        unique case (state_reg)
            S_IDLE:  if (s_tvalid) state_next = S_CHECK;
            S_CHECK: begin
                if (req_reg.command == CMD_CLEAR) state_next = S_CLEAR;
                else if (bad_idx || req_reg.command == CMD_MAP_WRITE) state_next = S_OUT;
                else state_next = S_RDCUR;
            end
            S_RDCUR: if (cnt_reg == 3'd3) state_next = S_PICK;
            S_PICK:  state_next = S_RDNXT;
            S_RDNXT: begin
                q_raddr = row_base_nxt + QAW'(cnt_reg[1:0]);
                if (cnt_reg == 3'd3) begin
                    state_next = (req_reg.command == CMD_LEARN) ? S_MUL : S_WRITE;
                end
            end
            S_MUL: begin
                mac_start = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE: begin
                if (req_reg.command == CMD_LEARN) begin
                    q_we = 1'b1;
                    q_waddr = row_base_cur + QAW'(act_reg);
                    q_wdata = mac_q;
                end
                state_next = S_OUT;
            end
            S_CLEAR: begin
                q_we = 1'b1;
                // The sweep after reset answers nothing; only a clear request does.
                if (32'(clr_reg) == QD - 1)
                    state_next = (req_reg.command == CMD_CLEAR) ? S_OUT : S_IDLE;
            end
            S_OUT:   if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
            total_reg <= '0;
            cfg_reg   <= '{16'd58982, 7'd10, -16'sd2560, -16'sd256};
            req_reg   <= '0;
            rsp_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_DISCOUNT: cfg_reg.discount_gain   <= cfg_data;
                    CFG_EXPLORE:  cfg_reg.explore_percent <= cfg_data[6:0];
                    CFG_BLOCKED:  cfg_reg.blocked_reward  <= cfg_data;
                    CFG_TURN:     cfg_reg.turn_penalty    <= cfg_data;
                endcase
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) req_reg <= s_req;
                    cnt_reg <= '0;
                    clr_reg <= '0;
                end
                S_CHECK: begin
                    rsp_reg <= '{action: ACT_LEFT, next_lane: '0, step_reward: '0,
                                 q_value: '0, total_reward: total_reg,
                                 error: (req_reg.command != CMD_CLEAR) && bad_idx};
                end
                S_RDCUR: begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg != 3'd0) cq_reg[cnt_reg[1:0] - 2'd1] <= q_rdata_reg;
                end
                S_PICK: begin
                    act_reg <= pick;
                    nl_reg  <= pnl;
                    blk_reg <= pblk;
                    cnt_reg <= '0;
                end
                S_RDNXT: begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd1) nmax_reg <= q_rdata_reg;
                    else if (cnt_reg != 3'd0 && $signed(q_rdata_reg) > nmax_reg)
                        nmax_reg <= q_rdata_reg;
                    if (cnt_reg == 3'd1) rew_reg <= rew_c;
                end
                S_WRITE: begin
                    rsp_reg.action <= act_reg;
                    rsp_reg.next_lane <= nl_reg;
                    rsp_reg.step_reward <= rew_reg;
                    if (req_reg.command == CMD_LEARN) begin
                        rsp_reg.q_value <= mac_q;
                    end else begin
                        if (tot_sum > 33'sh07FFFFFFF) total_reg <= 32'sh7FFFFFFF;
                        else if (tot_sum < -33'sh080000000) total_reg <= 32'sh80000000;
                        else total_reg <= tot_sum[31:0];
                        if (tot_sum > 33'sh07FFFFFFF)
                            rsp_reg.total_reward <= 32'sh7FFFFFFF;
                        else if (tot_sum < -33'sh080000000)
                            rsp_reg.total_reward <= 32'sh80000000;
                        else rsp_reg.total_reward <= tot_sum[31:0];
                    end
                end
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (req_reg.command == CMD_CLEAR) begin
                        total_reg <= '0;
                        rsp_reg.total_reward <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {M_TDATA_W{1'b0}} | M_TDATA_W'({rsp_reg.error, rsp_reg.total_reward,
                      rsp_reg.q_value, rsp_reg.step_reward, rsp_reg.next_lane, rsp_reg.action});

    logic unused;
    assign unused = ^s_tdata[S_TDATA_W-1:44];

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("ready while result pending");
    a_clr_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> 32'(clr_reg) < QD) else $error("clear overran");
    a_wr_learn: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_we && state_reg == S_WRITE) |-> req_reg.command == CMD_LEARN)
        else $error("Q write outside learn");
endmodule
